### src/bfsk_pkg.sv
package bfsk_pkg;

  // Fixed field and datapath widths
  localparam int unsigned PHASE_W    = 32;
  localparam int unsigned STEP_W     = 31;
  localparam int unsigned SPB_W      = 16;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned BITS_W     = 4;
  localparam int unsigned TBL_DEPTH  = 1024;
  localparam int unsigned TBL_AW     = $clog2(TBL_DEPTH);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_SPACE_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARK_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPB        = 2'd2;

  localparam logic [STEP_W-1:0] SPACE_STEP_RST = 31'd97391549;
  localparam logic [STEP_W-1:0] MARK_STEP_RST  = 31'd194783097;
  localparam logic [SPB_W-1:0]  SPB_RST        = 16'd4410;

  // Request kinds carried on the input tuser
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  localparam logic [BITS_W-1:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic sample_valid;
    logic byte_accepted;
    logic last_sample;
    logic ready_for_byte;
  } rsp_flags_t;

  typedef logic signed [SAMPLE_W-1:0] sine_tbl_t [TBL_DEPTH];

  // One table entry: quarter-wave polynomial in Q15, mirrored and signed per quadrant
  function automatic logic signed [SAMPLE_W-1:0] sine_entry(input int unsigned idx);
    longint u;
    longint quad;
    longint r;
    longint z;
    longint z2;
    longint t;
    longint m;
    u    = (longint'(idx) << 16) / TBL_DEPTH;
    quad = (u >> 14) & 3;
    r    = u & 16383;
    if ((quad & 1) != 0) begin
      r = 16384 - r;
    end
    z  = r * 2;
    z2 = (z * z) >> 15;
    t  = 153;
    t  = 2611 - ((t * z2) >> 15);
    t  = 21167 - ((t * z2) >> 15);
    t  = 51472 - ((t * z2) >> 15);
    m  = (t * z) >> 15;
    if (m > 32767) begin
      m = 32767;
    end
    // Scale the Q1.15 magnitude to the sample width
    if (SAMPLE_W > 16) begin
      m = m << (SAMPLE_W - 16);
    end else begin
      m = m >> (16 - SAMPLE_W);
    end
    if ((quad & 2) != 0) begin
      m = -m;
    end
    return SAMPLE_W'(m);
  endfunction

  function automatic sine_tbl_t sine_tbl_gen();
    sine_tbl_t tbl;
    for (int unsigned i = 0; i < TBL_DEPTH; i++) begin
      tbl[i] = sine_entry(i);
    end
    return tbl;
  endfunction

endpackage

### src/binary_fsk_tone_modulator.sv
// Binary FSK tone modulator. Each input beat is either a load (tuser high),
// which hands over a data byte on tdata with the end-of-packet flag on tlast,
// or a sample tick (tuser low). Every input beat yields exactly one output
// beat, in order. An accepted load starts the byte; bits go out MSB first,
// each for samples_per_bit ticks at the mark (one) or space (zero) phase
// step, and the phase restarts at zero on every bit. A load while a byte is
// still in flight is refused (byte_accepted low). A tick while idle returns a
// zero sample with the valid flag (output tuser) low. The final sample of a
// byte loaded with end-of-packet set carries tlast. Samples come from a
// 1024-entry Q1.15 full-wave sine ROM addressed by the top phase bits.
// Rate: one input beat per clock, sustained, as long as the output side takes
// beats. An input beat passes the registered ROM read and then the output
// register, which lets an input beat enter while a finished beat still waits.
// Configuration writes take effect on the next tick and must only be made
// while the block is idle.
module binary_fsk_tone_modulator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // [7:0] data_byte
  input  logic                                s_axis_tuser,  // [0] req_type
  input  logic                                s_axis_tlast,  // end_of_packet
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [15:0] sample, [16] byte_accepted, [17] ready_for_byte, [23:18] zero
  output logic [23:0]                         m_axis_tdata,
  output logic                                m_axis_tuser,  // [0] sample_valid
  output logic                                m_axis_tlast,  // last_sample
  input  logic                                cfg_we_i,
  input  logic [bfsk_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bfsk_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import bfsk_pkg::*;

  // Constant sine ROM, read synchronously
  localparam sine_tbl_t SineRom = sine_tbl_gen();

  // Configuration registers
  logic [STEP_W-1:0]  space_step_q;
  logic [STEP_W-1:0]  mark_step_q;
  logic [SPB_W-1:0]   spb_q;

  // Modulator context
  logic [7:0]         bit_shift_q,    bit_shift_d;
  logic [BITS_W-1:0]  bits_left_q,    bits_left_d;
  logic [SPB_W-1:0]   sample_count_q, sample_count_d;
  logic [PHASE_W-1:0] phase_acc_q,    phase_acc_d;
  logic               final_byte_q,   final_byte_d;
  logic               busy_q,         busy_d;

  // ROM read stage and output register
  logic                       s1_vld_q;
  rsp_flags_t                 s1_flags_q, s1_flags_d;
  logic signed [SAMPLE_W-1:0] rom_q;
  logic                       out_vld_q;
  rsp_flags_t                 out_flags_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;

  logic               adv;
  logic               in_beat;
  logic [STEP_W-1:0]  step;
  logic               bit_done;

  // The output register frees when empty or taken; stage 1 moves on then
  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !s1_vld_q || adv;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  assign step     = bit_shift_q[7] ? mark_step_q : space_step_q;
  assign bit_done = ({1'b0, sample_count_q} + 17'd1) >= {1'b0, spb_q};

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      space_step_q <= SPACE_STEP_RST;
      mark_step_q  <= MARK_STEP_RST;
      spb_q        <= SPB_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SPACE_STEP: space_step_q <= cfg_data_i;
        CFG_MARK_STEP:  mark_step_q  <= cfg_data_i;
        CFG_SPB:        spb_q        <= cfg_data_i[SPB_W-1:0];
        default:        ;
      endcase
    end
  end

  // Context update for one input beat
  always_comb begin
    bit_shift_d    = bit_shift_q;
    bits_left_d    = bits_left_q;
    sample_count_d = sample_count_q;
    phase_acc_d    = phase_acc_q;
    final_byte_d   = final_byte_q;
    busy_d         = busy_q;
    s1_flags_d     = '0;

    if (s_axis_tuser == REQ_LOAD) begin
      if (!busy_q) begin
        bit_shift_d              = s_axis_tdata;
        bits_left_d              = BITS_PER_BYTE;
        sample_count_d           = '0;
        phase_acc_d              = '0;
        final_byte_d             = s_axis_tlast;
        busy_d                   = 1'b1;
        s1_flags_d.byte_accepted = 1'b1;
      end
    end else if (busy_q) begin
      s1_flags_d.sample_valid = 1'b1;
      if (bit_done) begin
        // Next bit: restart phase and count
        sample_count_d = '0;
        phase_acc_d    = '0;
        bit_shift_d    = {bit_shift_q[6:0], 1'b0};
        bits_left_d    = bits_left_q - 1'b1;
        if (bits_left_q == 4'd1) begin
          busy_d                 = 1'b0;
          s1_flags_d.last_sample = final_byte_q;
        end
      end else begin
        sample_count_d = sample_count_q + 1'b1;
        phase_acc_d    = phase_acc_q + PHASE_W'(step);
      end
    end
    s1_flags_d.ready_for_byte = !busy_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_shift_q    <= '0;
      bits_left_q    <= '0;
      sample_count_q <= '0;
      phase_acc_q    <= '0;
      final_byte_q   <= 1'b0;
      busy_q         <= 1'b0;
    end else if (in_beat) begin
      bit_shift_q    <= bit_shift_d;
      bits_left_q    <= bits_left_d;
      sample_count_q <= sample_count_d;
      phase_acc_q    <= phase_acc_d;
      final_byte_q   <= final_byte_d;
      busy_q         <= busy_d;
    end
  end

  // ROM read at the phase held before the update; hold data while stalled
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      rom_q <= SineRom[phase_acc_q[PHASE_W-1 -: TBL_AW]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      s1_flags_q <= '0;
    end else if (in_beat) begin
      s1_vld_q   <= 1'b1;
      s1_flags_q <= s1_flags_d;
    end else if (adv) begin
      s1_vld_q   <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q   <= 1'b0;
      out_flags_q <= '0;
    end else if (adv) begin
      out_vld_q   <= s1_vld_q;
      out_flags_q <= s1_flags_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_sample_q <= s1_flags_q.sample_valid ? rom_q : '0;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, out_flags_q.ready_for_byte, out_flags_q.byte_accepted,
                          out_sample_q};
  assign m_axis_tuser  = out_flags_q.sample_valid;
  assign m_axis_tlast  = out_flags_q.last_sample;

`ifndef NO_ASSERTIONS
  a_busy_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q == (bits_left_q != '0))
    else $error("busy flag disagrees with bits left");

  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (s_axis_tuser == REQ_LOAD) && !busy_q |=> busy_q)
    else $error("accepted load did not start a byte");

  a_zero_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[15:0] == 16'd0)
    else $error("nonzero sample without valid flag");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser && m_axis_tdata[16]))
    else $error("sample and byte acceptance in one beat");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser && m_axis_tdata[17])
    else $error("last sample without valid sample or return to idle");
`endif

endmodule

### sim/binary_fsk_tone_modulator_tb.sv
module binary_fsk_tone_modulator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bfsk_pkg::*;

  // One output beat as seen on the master side, broken into its fields.
  typedef struct packed {
    logic [5:0]  pad;
    logic [15:0] sample;
    logic        sample_valid;
    logic        byte_accepted;
    logic        last_sample;
    logic        ready_for_byte;
  } tone_beat_t;

  // Tracks the modulator state, predicts one beat per accepted request and
  // checks returned beats against the oldest prediction.
  class fsk_tone_scoreboard;
    int unsigned  errors;
    tone_beat_t   expected_beats[$];

    logic [30:0]  space_step;
    logic [30:0]  mark_step;
    logic [15:0]  spb;

    logic [7:0]   bit_shift;
    logic [3:0]   bits_left;
    logic [15:0]  sample_cnt;
    logic [31:0]  phase;
    logic         eop_byte;
    logic         busy;

    function new();
      errors     = 0;
      space_step = SPACE_STEP_RST;
      mark_step  = MARK_STEP_RST;
      spb        = SPB_RST;
      bit_shift  = '0;
      bits_left  = '0;
      sample_cnt = '0;
      phase      = '0;
      eop_byte   = 1'b0;
      busy       = 1'b0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_SPACE_STEP: space_step = val;
        CFG_MARK_STEP:  mark_step  = val;
        CFG_SPB:        spb        = val[15:0];
        default: ;
      endcase
    endfunction

    // Full-turn sine: top ten phase bits pick the slot, two of them the quadrant.
    function logic [15:0] tone_sample(logic [31:0] ph);
      logic [9:0]      slot;
      longint unsigned frac;
      longint unsigned z;
      longint unsigned z2;
      longint unsigned poly;
      longint unsigned mag;
      logic [15:0]     res;
      slot = ph[31:22];
      frac = {slot[7:0], 6'b0};
      if (slot[8]) frac = 16384 - frac;
      z    = frac << 1;
      z2   = (z * z) >> 15;
      poly = 153;
      poly = 2611 - ((poly * z2) >> 15);
      poly = 21167 - ((poly * z2) >> 15);
      poly = 51472 - ((poly * z2) >> 15);
      mag  = (poly * z) >> 15;
      if (mag > 32767) mag = 32767;
      res = mag[15:0];
      if (slot[9]) res = -res;
      return res;
    endfunction

    function void predict_request(logic req, logic [7:0] data, logic eop);
      tone_beat_t want;
      logic       mark_bit;
      want = '0;
      if (req == REQ_LOAD) begin
        if (!busy) begin
          bit_shift          = data;
          bits_left          = BITS_PER_BYTE;
          sample_cnt         = '0;
          phase              = '0;
          eop_byte           = eop;
          busy               = 1'b1;
          want.byte_accepted = 1'b1;
        end
      end else if (busy) begin
        mark_bit          = bit_shift[7];
        want.sample       = tone_sample(phase);
        want.sample_valid = 1'b1;
        phase = phase + (mark_bit ? {1'b0, mark_step} : {1'b0, space_step});
        // a zero bit length acts as one sample per bit
        if (32'(sample_cnt) + 1 >= 32'(spb)) begin
          sample_cnt = '0;
          phase      = '0;
          bit_shift  = {bit_shift[6:0], 1'b0};
          bits_left  = bits_left - 1'b1;
          if (bits_left == 0) begin
            busy             = 1'b0;
            want.last_sample = eop_byte;
          end
        end else begin
          sample_cnt = sample_cnt + 1'b1;
        end
      end
      want.ready_for_byte = !busy;
      expected_beats.push_back(want);
    endfunction

    function void compare_field(string name, int want, int got, time at_ns);
      if (want != got) begin
        errors++;
        if (errors <= 100)
          $display("%0d ns: %s mismatch: expected %0d, actual %0d", at_ns, name, want, got);
      end
    endfunction

    function void check_beat(tone_beat_t got, time at_ns);
      tone_beat_t want;
      if (expected_beats.size() == 0) begin
        errors++;
        if (errors <= 100)
          $display("%0d ns: unexpected beat: expected none, actual sample %0d flags %b",
                   at_ns, $signed(got.sample),
                   {got.sample_valid, got.byte_accepted, got.last_sample, got.ready_for_byte});
        return;
      end
      want = expected_beats.pop_front();
      compare_field("sample", int'($signed(want.sample)), int'($signed(got.sample)), at_ns);
      compare_field("sample_valid", want.sample_valid, got.sample_valid, at_ns);
      compare_field("byte_accepted", want.byte_accepted, got.byte_accepted, at_ns);
      compare_field("last_sample", want.last_sample, got.last_sample, at_ns);
      compare_field("ready_for_byte", want.ready_for_byte, got.ready_for_byte, at_ns);
      compare_field("tdata padding", want.pad, got.pad, at_ns);
    endfunction

    function int unsigned pending();
      return expected_beats.size();
    endfunction
  endclass

  localparam int unsigned HOLD_CYCLES  = 64;     // long receiver hold-off
  localparam int unsigned PHASE_ITEMS  = 150;    // minimum requests per random phase
  localparam int unsigned LONG_TICKS   = 150;    // ticks into the longest bit

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;      // [7:0] data_byte
  logic                  s_axis_tuser = 1'b0;    // [0] req_type
  logic                  s_axis_tlast = 1'b0;    // end_of_packet
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [15:0] sample, [16] byte_accepted, [17] ready_for_byte, [23:18] zero
  logic [23:0]           m_axis_tdata;
  logic                  m_axis_tuser;           // [0] sample_valid
  logic                  m_axis_tlast;           // last_sample
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  fsk_tone_scoreboard tone_sb = new();

  bit           steady        = 1'b0;   // suppress idling on both sides
  bit           hold_off_req  = 1'b0;   // ask the receiver for one long stall
  logic [15:0]  cur_spb       = SPB_RST;
  int unsigned  items_sent    = 0;

  binary_fsk_tone_modulator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watch both handshakes at the edge. Note the request beat before checking
  // the result beat, so ordering stays right even if a result left with its request.
  always @(posedge clk_i) begin : beat_monitor
    tone_beat_t got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        tone_sb.predict_request(s_axis_tuser, s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        got.pad            = m_axis_tdata[23:18];
        got.sample         = m_axis_tdata[15:0];
        got.sample_valid   = m_axis_tuser;
        got.byte_accepted  = m_axis_tdata[16];
        got.last_sample    = m_axis_tlast;
        got.ready_for_byte = m_axis_tdata[17];
        tone_sb.check_beat(got, $time);
      end
    end
  end

  // Receiver: stall about 30% of the time; on request hold off for a long
  // stretch so the block fills up and pushes back on its input.
  initial begin : result_sink
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      m_axis_tready <= steady || ($urandom_range(99) >= 30);
    end
  end

  // Offer one request beat, with random idle cycles ahead of it, and hold it
  // until the block takes it. Valid stays high for a back-to-back next beat.
  task automatic send_item(input logic req, input logic [7:0] data, input logic eop);
    while (!steady && $urandom_range(99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= data;
    s_axis_tlast  <= eop;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic send_tick();
    send_item(REQ_TICK, 8'($urandom), 1'($urandom));
  endtask

  // Load one byte and tick it out completely; sprinkle refused loads in
  // between the ticks at the given percentage.
  task automatic send_byte(input logic [7:0] data, input logic eop,
                           input int unsigned refuse_pct);
    int unsigned ticks;
    ticks = 8 * ((cur_spb == 0) ? 1 : int'(cur_spb));
    send_item(REQ_LOAD, data, eop);
    repeat (ticks) begin
      if ($urandom_range(99) < refuse_pct)
        send_item(REQ_LOAD, 8'($urandom), 1'($urandom));
      send_tick();
    end
  endtask

  // Drop valid and wait until every predicted beat has come back, then let
  // the pipeline settle before touching the registers.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (tone_sb.pending() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    tone_sb.set_register(idx, val);
    if (idx == CFG_SPB) cur_spb = val[15:0];
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_step();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_spb();
    case ($urandom_range(9))
      0:       return '0;
      1:       return CFG_DATA_W'($urandom_range(20, 48));
      default: return CFG_DATA_W'($urandom_range(1, 10));
    endcase
  endfunction

  initial begin : stimulus
    int unsigned phase_start;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset tone steps with two samples per bit. Tick while idle,
    // accept a flagged byte, refuse a load while busy, run it out to the
    // last-sample mark, then tick idle again.
    write_reg(CFG_SPB, CFG_DATA_W'(2));
    send_tick();
    send_item(REQ_LOAD, 8'hF0, 1'b1);
    send_item(REQ_LOAD, 8'h0F, 1'b0);
    repeat (16) send_tick();
    send_tick();

    // Directed: zero bit length behaves as one sample per bit.
    drain_results();
    write_reg(CFG_SPB, '0);
    send_byte(8'h5A, 1'b0, 0);

    // Random phases: new settings each time, well-formed bytes with some
    // refused loads and idle ticks mixed in. Phase 0 pins the step extremes,
    // phase 1 gets the long receiver hold-off, phase 2 runs without idling.
    for (int p = 0; p < 7; p++) begin
      drain_results();
      write_reg(CFG_SPACE_STEP, (p == 0) ? '0 : pick_step());
      write_reg(CFG_MARK_STEP,  (p == 0) ? '1 : pick_step());
      write_reg(CFG_SPB,        pick_spb());
      if (p == 1) hold_off_req = 1'b1;
      steady = (p == 2);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        send_byte(8'($urandom), 1'($urandom), 6);
        if ($urandom_range(99) < 20)
          repeat ($urandom_range(1, 3)) send_tick();
      end
    end
    steady = 1'b0;

    // Longest bit: start a byte and run well into its first bit. The block is
    // left busy at the end, so refused loads are still checked here.
    drain_results();
    write_reg(CFG_SPACE_STEP, pick_step());
    write_reg(CFG_MARK_STEP, pick_step());
    write_reg(CFG_SPB, CFG_DATA_W'(16'hFFFF));
    send_item(REQ_LOAD, 8'($urandom), 1'b1);
    repeat (LONG_TICKS) begin
      if ($urandom_range(99) < 5)
        send_item(REQ_LOAD, 8'($urandom), 1'($urandom));
      send_tick();
    end
    drain_results();

    if (tone_sb.errors == 0 && tone_sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### sim.f
src/bfsk_pkg.sv
src/binary_fsk_tone_modulator.sv
sim/binary_fsk_tone_modulator_tb.sv
